[rtl/core/mdfs_pkg.sv]
package mdfs_pkg;

  localparam int unsigned DefMaxColumns = 32;
  localparam int unsigned DefMaxRows    = 32;

  localparam int unsigned CfgW      = 6;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned DrawW     = 16;
  localparam int unsigned CoordOutW = 5;
  localparam int unsigned DirW      = 2;
  localparam int unsigned DimW      = 9;
  localparam int unsigned AreaW     = 2 * CfgW;
  localparam int unsigned CntCmpW   = 17;
  localparam int unsigned OutDataW  = 24;

  localparam logic [CfgW-1:0] CfgReset = 6'd8;
  localparam logic [CfgW-1:0] CfgMin   = 6'd2;

  localparam logic [CfgIdxW-1:0] CfgIdxColumns = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIdxRows    = 1'b1;

  localparam logic [DirW-1:0] DirUp    = 2'd0;
  localparam logic [DirW-1:0] DirLeft  = 2'd1;
  localparam logic [DirW-1:0] DirRight = 2'd2;
  localparam logic [DirW-1:0] DirDown  = 2'd3;

  typedef struct packed {
    logic finished;
    logic backtracked;
    logic carved;
  } kind_t;

  typedef struct packed {
    logic [CoordOutW-1:0] to_row;
    logic [CoordOutW-1:0] to_column;
    logic [DirW-1:0]      direction;
    logic [CoordOutW-1:0] from_row;
    logic [CoordOutW-1:0] from_column;
  } res_data_t;

  typedef struct packed {
    logic      valid;
    kind_t     kind;
    res_data_t data;
  } step_res_t;

  function automatic logic [1:0] mod3(input logic [DrawW-1:0] v);
    logic [4:0] s;
    s = '0;
    for (int i = 0; i < DrawW / 2; i++) begin
      s = s + {3'b000, v[2*i +: 2]};
    end
    if (s >= 5'd12) s = s - 5'd12;
    if (s >= 5'd12) s = s - 5'd12;
    if (s >= 5'd6) s = s - 5'd6;
    if (s >= 5'd3) s = s - 5'd3;
    return s[1:0];
  endfunction

endpackage

[rtl/core/mdfs_nbr.sv]
module mdfs_nbr #(
  parameter int unsigned MAX_COLUMNS = mdfs_pkg::DefMaxColumns,
  parameter int unsigned MAX_ROWS    = mdfs_pkg::DefMaxRows
) (
  input  logic [$clog2(MAX_COLUMNS)-1:0]          cur_col_i,
  input  logic [$clog2(MAX_ROWS)-1:0]             cur_row_i,
  input  logic [mdfs_pkg::DirW-1:0]               dir_i,
  input  logic [mdfs_pkg::CfgW-1:0]               cols_i,
  input  logic [mdfs_pkg::CfgW-1:0]               rows_i,
  output logic [$clog2(MAX_COLUMNS)-1:0]          nb_col_o,
  output logic [$clog2(MAX_ROWS)-1:0]             nb_row_o,
  output logic                                    ok_o,
  output logic [$clog2(MAX_COLUMNS*MAX_ROWS)-1:0] addr_o
);

  localparam int unsigned CW   = $clog2(MAX_COLUMNS);
  localparam int unsigned RW   = $clog2(MAX_ROWS);
  localparam int unsigned AW   = $clog2(MAX_COLUMNS * MAX_ROWS);
  localparam int unsigned DimW = mdfs_pkg::DimW;
  localparam logic [AW-1:0] ColStride = AW'(MAX_COLUMNS);

  logic [DimW-1:0] col_ext;
  logic [DimW-1:0] row_ext;
  logic [DimW-1:0] nc;
  logic [DimW-1:0] nr;
  logic            in_low;

  always_comb begin
    col_ext = DimW'(cur_col_i);
    row_ext = DimW'(cur_row_i);
    nc      = col_ext;
    nr      = row_ext;
    in_low  = 1'b1;
    case (dir_i)
      mdfs_pkg::DirUp: begin
        in_low = (cur_col_i != '0);
        nc     = col_ext - DimW'(1);
      end
      mdfs_pkg::DirLeft: begin
        in_low = (cur_row_i != '0);
        nr     = row_ext - DimW'(1);
      end
      mdfs_pkg::DirRight: begin
        nr = row_ext + DimW'(1);
      end
      mdfs_pkg::DirDown: begin
        nc = col_ext + DimW'(1);
      end
      default: begin
        in_low = 1'b0;
      end
    endcase
  end

  assign ok_o     = in_low && (nc < DimW'(cols_i)) && (nr < DimW'(rows_i));
  assign nb_col_o = nc[CW-1:0];
  assign nb_row_o = nr[RW-1:0];
  assign addr_o   = ok_o ? AW'(AW'(nb_row_o) * ColStride + AW'(nb_col_o)) : '0;

endmodule

[rtl/core/mdfs_walk.sv]
module mdfs_walk #(
  parameter int unsigned MAX_COLUMNS = mdfs_pkg::DefMaxColumns,
  parameter int unsigned MAX_ROWS    = mdfs_pkg::DefMaxRows
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [mdfs_pkg::CfgW-1:0]    cols_i,
  input  logic [mdfs_pkg::CfgW-1:0]    rows_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [mdfs_pkg::DrawW-1:0]   draw_i,
  input  logic                         out_free_i,
  output mdfs_pkg::step_res_t          res_o
);

  localparam int unsigned CW        = $clog2(MAX_COLUMNS);
  localparam int unsigned RW        = $clog2(MAX_ROWS);
  localparam int unsigned CellCount = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned AW        = $clog2(CellCount);
  localparam int unsigned VCW       = $clog2(CellCount + 1);
  localparam int unsigned DirW      = mdfs_pkg::DirW;

  localparam logic [2:0] StClear  = 3'd0;
  localparam logic [2:0] StIdle   = 3'd1;
  localparam logic [2:0] StProbe  = 3'd2;
  localparam logic [2:0] StChoose = 3'd3;
  localparam logic [2:0] StMove   = 3'd4;
  localparam logic [2:0] StPop    = 3'd5;
  localparam logic [2:0] StEmit   = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [AW-1:0]        clr_addr_q, clr_addr_d;
  logic [CW-1:0]        cur_col_q, cur_col_d;
  logic [RW-1:0]        cur_row_q, cur_row_d;
  logic [VCW-1:0]       depth_q, depth_d;
  logic [VCW-1:0]       vcount_q, vcount_d;
  logic [DirW-1:0]      dir_q, dir_d;
  logic [3:0]           okm_q, okm_d;
  logic [2:0]           open_q, open_d;
  logic [1:0]           draw_lo_q, draw_lo_d;
  logic [1:0]           mod3_q, mod3_d;
  logic [CW-1:0]        from_col_q, from_col_d;
  logic [RW-1:0]        from_row_q, from_row_d;
  mdfs_pkg::kind_t      kind_q, kind_d;

  logic [CW-1:0]        nb_col;
  logic [RW-1:0]        nb_row;
  logic                 nb_ok;
  logic [AW-1:0]        nb_addr;

  logic                 vis_mem [CellCount];
  logic                 vis_rdata_q;
  logic                 vis_we;
  logic [AW-1:0]        vis_waddr;
  logic                 vis_wdata;

  logic [CW-1:0]        stk_col_mem [CellCount];
  logic [RW-1:0]        stk_row_mem [CellCount];
  logic [CW-1:0]        stk_col_q;
  logic [RW-1:0]        stk_row_q;
  logic                 stk_we;
  logic [VCW-1:0]       stk_raddr_full;
  logic [AW-1:0]        stk_raddr;
  logic [AW-1:0]        stk_waddr;

  logic [mdfs_pkg::AreaW-1:0] area;
  logic                 done_now;
  logic [3:0]           mask;
  logic [2:0]           ncnt;
  logic [1:0]           pick;
  logic [2:0]           seen;
  logic [DirW-1:0]      sel_dir;
  logic                 res_valid;

  mdfs_nbr #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_nbr (
    .cur_col_i(cur_col_q),
    .cur_row_i(cur_row_q),
    .dir_i    (dir_q),
    .cols_i   (cols_i),
    .rows_i   (rows_i),
    .nb_col_o (nb_col),
    .nb_row_o (nb_row),
    .ok_o     (nb_ok),
    .addr_o   (nb_addr)
  );

  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    vis_rdata_q <= vis_mem[nb_addr];
  end

  assign stk_raddr_full = depth_q - VCW'(1);
  assign stk_raddr      = stk_raddr_full[AW-1:0];
  assign stk_waddr      = depth_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_col_mem[stk_waddr] <= cur_col_q;
      stk_row_mem[stk_waddr] <= cur_row_q;
    end
    stk_col_q <= stk_col_mem[stk_raddr];
    stk_row_q <= stk_row_mem[stk_raddr];
  end

  assign area     = mdfs_pkg::AreaW'({6'b0, cols_i} * {6'b0, rows_i});
  assign done_now = mdfs_pkg::CntCmpW'(vcount_q) >= mdfs_pkg::CntCmpW'(area);

  assign mask = {okm_q[3] & ~vis_rdata_q, open_q};
  assign ncnt = 3'($countones(mask));

  always_comb begin
    case (ncnt)
      3'd2:    pick = {1'b0, draw_lo_q[0]};
      3'd3:    pick = mod3_q;
      3'd4:    pick = draw_lo_q;
      default: pick = 2'd0;
    endcase
  end

  always_comb begin
    seen    = '0;
    sel_dir = mdfs_pkg::DirUp;
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        if (seen == {1'b0, pick}) sel_dir = DirW'(i);
        seen = seen + 3'd1;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    cur_col_d  = cur_col_q;
    cur_row_d  = cur_row_q;
    depth_d    = depth_q;
    vcount_d   = vcount_q;
    dir_d      = dir_q;
    okm_d      = okm_q;
    open_d     = open_q;
    draw_lo_d  = draw_lo_q;
    mod3_d     = mod3_q;
    from_col_d = from_col_q;
    from_row_d = from_row_q;
    kind_d     = kind_q;
    vis_we     = 1'b0;
    vis_waddr  = nb_addr;
    vis_wdata  = 1'b1;
    stk_we     = 1'b0;
    in_ready_o = 1'b0;
    res_valid  = 1'b0;
    case (state_q)
      StClear: begin
        vis_we     = 1'b1;
        vis_waddr  = clr_addr_q;
        vis_wdata  = (clr_addr_q == '0);
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(CellCount - 1)) state_d = StIdle;
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          from_col_d = cur_col_q;
          from_row_d = cur_row_q;
          draw_lo_d  = draw_i[1:0];
          mod3_d     = mdfs_pkg::mod3(draw_i);
          dir_d      = mdfs_pkg::DirUp;
          if (done_now) begin
            kind_d  = '{finished: 1'b1, backtracked: 1'b0, carved: 1'b0};
            state_d = StEmit;
          end else begin
            state_d = StProbe;
          end
        end
      end
      StProbe: begin
        okm_d[dir_q] = nb_ok;
        if (dir_q != mdfs_pkg::DirUp) begin
          open_d = {okm_q[dir_q - 2'd1] & ~vis_rdata_q, open_q[2:1]};
        end
        dir_d = dir_q + 2'd1;
        if (dir_q == mdfs_pkg::DirDown) state_d = StChoose;
      end
      StChoose: begin
        if (ncnt != 3'd0) begin
          dir_d   = sel_dir;
          kind_d  = '{finished: 1'b0, backtracked: 1'b0, carved: 1'b1};
          state_d = StMove;
        end else begin
          dir_d  = mdfs_pkg::DirUp;
          kind_d = '{finished: 1'b0, backtracked: 1'b1, carved: 1'b0};
          if (depth_q != '0) begin
            depth_d = depth_q - VCW'(1);
            state_d = StPop;
          end else begin
            state_d = StEmit;
          end
        end
      end
      StMove: begin
        vis_we   = 1'b1;
        vcount_d = vcount_q + VCW'(1);
        if (depth_q < VCW'(CellCount)) begin
          stk_we  = 1'b1;
          depth_d = depth_q + VCW'(1);
        end
        cur_col_d = nb_col;
        cur_row_d = nb_row;
        state_d   = StEmit;
      end
      StPop: begin
        cur_col_d = stk_col_q;
        cur_row_d = stk_row_q;
        state_d   = StEmit;
      end
      StEmit: begin
        if (out_free_i) begin
          res_valid = 1'b1;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClear;
      clr_addr_q <= '0;
      cur_col_q  <= '0;
      cur_row_q  <= '0;
      depth_q    <= '0;
      vcount_q   <= VCW'(1);
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      cur_col_q  <= cur_col_d;
      cur_row_q  <= cur_row_d;
      depth_q    <= depth_d;
      vcount_q   <= vcount_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dir_q      <= dir_d;
    okm_q      <= okm_d;
    open_q     <= open_d;
    draw_lo_q  <= draw_lo_d;
    mod3_q     <= mod3_d;
    from_col_q <= from_col_d;
    from_row_q <= from_row_d;
    kind_q     <= kind_d;
  end

  always_comb begin
    res_o                  = '0;
    res_o.valid            = res_valid;
    res_o.kind             = kind_q;
    res_o.data.from_column = mdfs_pkg::CoordOutW'(from_col_q);
    res_o.data.from_row    = mdfs_pkg::CoordOutW'(from_row_q);
    res_o.data.direction   = dir_q;
    res_o.data.to_column   = mdfs_pkg::CoordOutW'(cur_col_q);
    res_o.data.to_row      = mdfs_pkg::CoordOutW'(cur_row_q);
  end

endmodule

[rtl/core/maze_dfs_step_engine_top.sv]
// Depth-first maze walker: each request carries a 16-bit random draw and returns one result
// that reports a carve, a backtrack or a finished maze. After reset the visited map is swept
// one cell per cycle, clearing all cells but the start cell, which is marked visited, before the
// first request is taken; configuration writes are accepted throughout. A carving step probes
// the four neighbors, chooses one and moves; a backtrack pops the stack unless it is empty; a
// finished report goes straight to the output. The four neighbor visited bits are read one
// per cycle through the single read port of the visited map by a shared neighbor unit, and a pop
// reads the top of the stack through its registered read port. A result waits in the output
// register while the next request is worked on.
module maze_dfs_step_engine_top #(
  parameter int unsigned MAX_COLUMNS = mdfs_pkg::DefMaxColumns,
  parameter int unsigned MAX_ROWS    = mdfs_pkg::DefMaxRows
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mdfs_pkg::CfgIdxW-1:0]    cfg_addr_i,
  input  logic [mdfs_pkg::CfgW-1:0]       cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // random_draw
  input  logic [mdfs_pkg::DrawW-1:0]      s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // from_column, from_row, direction, to_column, to_row, zero fill
  output logic [mdfs_pkg::OutDataW-1:0]   m_axis_tdata,
  // carved, backtracked, finished
  output logic [2:0]                      m_axis_tuser
);

  localparam int unsigned DimW = mdfs_pkg::DimW;
  localparam int unsigned CfgW = mdfs_pkg::CfgW;
  localparam logic [DimW-1:0] MaxColsDim = DimW'(MAX_COLUMNS);
  localparam logic [DimW-1:0] MaxRowsDim = DimW'(MAX_ROWS);

  logic [CfgW-1:0]     cols_cfg_q;
  logic [CfgW-1:0]     rows_cfg_q;
  logic [CfgW-1:0]     cols_eff;
  logic [CfgW-1:0]     rows_eff;
  logic                out_valid_q;
  mdfs_pkg::res_data_t out_data_q;
  mdfs_pkg::kind_t     out_kind_q;
  logic                out_free;
  mdfs_pkg::step_res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_cfg_q <= mdfs_pkg::CfgReset;
      rows_cfg_q <= mdfs_pkg::CfgReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        mdfs_pkg::CfgIdxColumns: cols_cfg_q <= cfg_data_i;
        mdfs_pkg::CfgIdxRows:    rows_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cols_cfg_q < mdfs_pkg::CfgMin) begin
      cols_eff = mdfs_pkg::CfgMin;
    end else if (DimW'(cols_cfg_q) > MaxColsDim) begin
      cols_eff = CfgW'(MAX_COLUMNS);
    end else begin
      cols_eff = cols_cfg_q;
    end
    if (rows_cfg_q < mdfs_pkg::CfgMin) begin
      rows_eff = mdfs_pkg::CfgMin;
    end else if (DimW'(rows_cfg_q) > MaxRowsDim) begin
      rows_eff = CfgW'(MAX_ROWS);
    end else begin
      rows_eff = rows_cfg_q;
    end
  end

  assign out_free = !out_valid_q || m_axis_tready;

  mdfs_walk #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_walk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cols_i    (cols_eff),
    .rows_i    (rows_eff),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .draw_i    (s_axis_tdata),
    .out_free_i(out_free),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_data_q <= res.data;
      out_kind_q <= res.kind;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = mdfs_pkg::OutDataW'(out_data_q);
  assign m_axis_tuser  = out_kind_q;

endmodule

[tb/sv/maze_dfs_step_engine_top_tb.sv]
module maze_dfs_step_engine_top_tb;

  localparam int          GridCols       = mdfs_pkg::DefMaxColumns;
  localparam int          GridRows       = mdfs_pkg::DefMaxRows;
  localparam int unsigned LongHoldCycles = 400;

  typedef struct packed {
    mdfs_pkg::kind_t     kind;
    mdfs_pkg::res_data_t data;
  } step_result_t;

  typedef enum logic [1:0] {RxFree, RxCoin, RxSparse, RxEveryThird} rx_pattern_e;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_we_i      = 1'b0;
  logic [mdfs_pkg::CfgIdxW-1:0]  cfg_addr_i    = '0;
  logic [mdfs_pkg::CfgW-1:0]     cfg_data_i    = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [mdfs_pkg::DrawW-1:0]    s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [mdfs_pkg::OutDataW-1:0] m_axis_tdata;
  logic [2:0]                    m_axis_tuser;

  // walk predictor state
  logic [mdfs_pkg::CfgW-1:0] columns_reg = mdfs_pkg::CfgReset;
  logic [mdfs_pkg::CfgW-1:0] rows_reg    = mdfs_pkg::CfgReset;
  bit              visited_cells [GridCols*GridRows];
  int              trail_cols [$];
  int              trail_rows [$];
  int              walk_col      = 0;
  int              walk_row      = 0;
  int              visited_total = 1;
  step_result_t    pending_steps [$];

  int unsigned     mismatch_count = 0;
  int unsigned     burst_left     = 0;
  bit              hold_request   = 1'b0;

  maze_dfs_step_engine_top #(
    .MAX_COLUMNS(GridCols),
    .MAX_ROWS   (GridRows)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #4000000;
    $display("maze_dfs_step_engine_top_tb: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  function automatic int effective_dim(input logic [mdfs_pkg::CfgW-1:0] value,
                                       input int limit);
    if (value < mdfs_pkg::CfgMin) return mdfs_pkg::CfgMin;
    if (value > limit) return limit;
    return value;
  endfunction

  function automatic void predict_step(input logic [mdfs_pkg::DrawW-1:0] draw);
    int                        cols;
    int                        rows;
    int                        open_count;
    int                        pick;
    int                        next_col;
    int                        next_row;
    int                        open_col [4];
    int                        open_row [4];
    logic [mdfs_pkg::DirW-1:0] open_dir [4];
    logic [mdfs_pkg::DirW-1:0] dir;
    step_result_t              step;
    cols = effective_dim(columns_reg, GridCols);
    rows = effective_dim(rows_reg, GridRows);
    step = '0;
    open_count = 0;
    step.data.from_column = mdfs_pkg::CoordOutW'(walk_col);
    step.data.from_row    = mdfs_pkg::CoordOutW'(walk_row);
    if (visited_total >= cols * rows) begin
      step.kind.finished = 1'b1;
    end else begin
      for (int d = 0; d < 4; d++) begin
        dir = mdfs_pkg::DirW'(d);
        next_col = walk_col;
        next_row = walk_row;
        case (dir)
          mdfs_pkg::DirUp:    next_col--;
          mdfs_pkg::DirLeft:  next_row--;
          mdfs_pkg::DirRight: next_row++;
          mdfs_pkg::DirDown:  next_col++;
          default: ;
        endcase
        if (next_col >= 0 && next_row >= 0 && next_col < cols && next_row < rows &&
            !visited_cells[next_row * GridCols + next_col]) begin
          open_col[open_count] = next_col;
          open_row[open_count] = next_row;
          open_dir[open_count] = dir;
          open_count++;
        end
      end
      if (open_count != 0) begin
        pick = draw % open_count;
        visited_cells[open_row[pick] * GridCols + open_col[pick]] = 1'b1;
        visited_total++;
        trail_cols.push_back(walk_col);
        trail_rows.push_back(walk_row);
        walk_col = open_col[pick];
        walk_row = open_row[pick];
        step.data.direction = open_dir[pick];
        step.kind.carved = 1'b1;
      end else begin
        step.kind.backtracked = 1'b1;
        if (trail_cols.size() != 0) begin
          walk_col = trail_cols.pop_back();
          walk_row = trail_rows.pop_back();
        end
      end
    end
    step.data.to_column = mdfs_pkg::CoordOutW'(walk_col);
    step.data.to_row    = mdfs_pkg::CoordOutW'(walk_row);
    pending_steps.push_back(step);
  endfunction

  task automatic write_cfg(input logic [mdfs_pkg::CfgIdxW-1:0] idx,
                           input logic [mdfs_pkg::CfgW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == mdfs_pkg::CfgIdxColumns) columns_reg = value;
    else rows_reg = value;
    @(posedge clk_i);
  endtask

  task automatic send_draw(input logic [mdfs_pkg::DrawW-1:0] draw);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= draw;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_step(draw);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [mdfs_pkg::CfgW-1:0] pick_dim();
    case ($urandom_range(0, 5))
      0:       return mdfs_pkg::CfgW'($urandom_range(0, 1));
      1:       return mdfs_pkg::CfgW'($urandom_range(33, 63));
      2:       return mdfs_pkg::CfgW'(GridCols);
      default: return mdfs_pkg::CfgW'($urandom_range(2, 32));
    endcase
  endfunction

  task automatic test_tiny_grid();
    write_cfg(mdfs_pkg::CfgIdxColumns, 6'd0);
    write_cfg(mdfs_pkg::CfgIdxRows, 6'd1);
    send_draw(16'hFFFF);
    send_draw(16'h0000);
    send_draw(16'h8000);
    send_draw(16'h5555);
    send_draw(16'hAAAA);
    wait_for_results();
  endtask

  task automatic test_wide_grid();
    write_cfg(mdfs_pkg::CfgIdxColumns, 6'd63);
    write_cfg(mdfs_pkg::CfgIdxRows, 6'd2);
    send_draw(16'h0001);
    send_draw(16'h0002);
    send_draw(16'h0003);
    send_draw(16'h7FFF);
    send_draw(16'h0000);
    send_draw(16'hFFFE);
    send_draw(16'h1234);
    send_draw(16'h0000);
    send_draw(16'hFFFF);
    send_draw(16'h0004);
    wait_for_results();
  endtask

  task automatic test_shrink_mid_walk();
    write_cfg(mdfs_pkg::CfgIdxColumns, 6'd2);
    write_cfg(mdfs_pkg::CfgIdxRows, 6'd33);
    for (int i = 0; i < 6; i++) send_draw(mdfs_pkg::DrawW'(i));
    wait_for_results();
    write_cfg(mdfs_pkg::CfgIdxColumns, 6'd3);
    write_cfg(mdfs_pkg::CfgIdxRows, 6'd3);
    send_draw(16'hC3A5);
    send_draw(16'h3C5A);
    wait_for_results();
  endtask

  task automatic test_random_walk();
    int unsigned steps;
    for (int phase = 0; phase < 15; phase++) begin
      if ($urandom_range(0, 3) != 0) write_cfg(mdfs_pkg::CfgIdxColumns, pick_dim());
      if ($urandom_range(0, 3) != 0) write_cfg(mdfs_pkg::CfgIdxRows, pick_dim());
      steps = $urandom_range(20, 90);
      repeat (steps) send_draw(mdfs_pkg::DrawW'($urandom));
      wait_for_results();
    end
  endtask

  task automatic test_backpressure();
    write_cfg(mdfs_pkg::CfgIdxColumns, mdfs_pkg::CfgW'(GridCols));
    write_cfg(mdfs_pkg::CfgIdxRows, mdfs_pkg::CfgW'(GridRows));
    hold_request <= ~hold_request;
    repeat (40) send_draw(mdfs_pkg::DrawW'($urandom));
    wait_for_results();
  endtask

  always @(posedge clk_i) begin
    step_result_t        want;
    mdfs_pkg::res_data_t got_data;
    mdfs_pkg::kind_t     got_kind;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_data = m_axis_tdata[$bits(mdfs_pkg::res_data_t)-1:0];
      got_kind = m_axis_tuser;
      if (m_axis_tdata[mdfs_pkg::OutDataW-1:$bits(mdfs_pkg::res_data_t)] != '0)
        report_mismatch("tdata fill",
                        m_axis_tdata[mdfs_pkg::OutDataW-1:$bits(mdfs_pkg::res_data_t)], 0);
      if (pending_steps.size() == 0) begin
        report_mismatch("result with no request pending", m_axis_tdata, 0);
      end else begin
        want = pending_steps.pop_front();
        if (got_kind.carved != want.kind.carved)
          report_mismatch("carved", got_kind.carved, want.kind.carved);
        if (got_kind.backtracked != want.kind.backtracked)
          report_mismatch("backtracked", got_kind.backtracked, want.kind.backtracked);
        if (got_kind.finished != want.kind.finished)
          report_mismatch("finished", got_kind.finished, want.kind.finished);
        if (got_data.from_column != want.data.from_column)
          report_mismatch("from_column", got_data.from_column, want.data.from_column);
        if (got_data.from_row != want.data.from_row)
          report_mismatch("from_row", got_data.from_row, want.data.from_row);
        if (got_data.direction != want.data.direction)
          report_mismatch("direction", got_data.direction, want.data.direction);
        if (got_data.to_column != want.data.to_column)
          report_mismatch("to_column", got_data.to_column, want.data.to_column);
        if (got_data.to_row != want.data.to_row)
          report_mismatch("to_row", got_data.to_row, want.data.to_row);
      end
    end
  end

  // hold off on request, otherwise stall on a changing pattern
  int unsigned hold_left  = 0;
  bit          hold_seen  = 1'b0;
  rx_pattern_e rx_pattern = RxFree;
  int unsigned rx_left    = 0;
  int unsigned rx_tick    = 0;

  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 1;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_request != hold_seen) begin
      hold_seen     <= hold_request;
      hold_left     <= LongHoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_pattern <= rx_pattern_e'($urandom_range(0, 3));
        rx_left    <= $urandom_range(8, 80);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_pattern)
        RxFree:   m_axis_tready <= 1'b1;
        RxCoin:   m_axis_tready <= ($urandom_range(0, 1) == 1);
        RxSparse: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:  m_axis_tready <= (rx_tick % 3 == 0);
      endcase
    end
  end

  initial begin
    visited_cells[0] = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_tiny_grid();
    test_wide_grid();
    test_shrink_mid_walk();
    test_random_walk();
    test_backpressure();
    wait_for_results();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("maze_dfs_step_engine_top_tb: done, clean");
    end else begin
      $display("maze_dfs_step_engine_top_tb: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/mdfs_pkg.sv
rtl/core/mdfs_nbr.sv
rtl/core/mdfs_walk.sv
rtl/core/maze_dfs_step_engine_top.sv
tb/sv/maze_dfs_step_engine_top_tb.sv
